// ===== hdl/fscd_pkg.sv =====
// Shared types and constants for the fan scan duty controller.
package fscd_pkg;

    localparam int PWM_PERIOD_COUNTS = 3200;
    localparam int STABLE_REPEATS    = 10;

    localparam int TEMP_W     = 10;
    localparam int OFFSET_W   = 8;
    localparam int POT_W      = 12;
    localparam int RPM_W      = 17;
    localparam int DUTY_W     = 12;
    localparam int SPEED_W    = 7;
    localparam int REPEAT_W   = 4;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // Bit-serial divider: quotient bits, divisor bits, dividend bits
    localparam int DIV_Q_W   = 12;
    localparam int DIV_D_W   = 20;
    localparam int DIV_N_W   = DIV_Q_W + DIV_D_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // Ratio numerator and denominator width
    localparam int NUM_W = 19;

    localparam logic [POT_W-1:0] POT_STEP_MASK = 12'hFF0;
    localparam int POT_SCALE_NUM  = 100368;
    localparam int POT_SCALE_DEN  = 100000;
    localparam int MANUAL_BASE    = 4096;
    localparam int MANUAL_DEN     = 409600;
    localparam int RAMP_SLOPE     = 99;
    localparam int RAMP_DEN_SCALE = 100;
    localparam int SPEED_NUM_MUL  = 200;
    localparam int SPEED_FULL     = 100;
    localparam int DUTY_FULL      = (PWM_PERIOD_COUNTS * 999) / 1000;

    localparam int CFG_LOW_TEMP_RST  = 50;
    localparam int CFG_HIGH_TEMP_RST = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_TEMP   = 2'd0,
        CFG_HIGH_TEMP  = 2'd1,
        CFG_CAL_OFFSET = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_reading;
        logic [POT_W-1:0]         pot_average;
        logic                     temp_mode_switch_n;
        logic                     manual_mode_switch_n;
        logic                     temp_display_switch_n;
        logic                     tach_display_switch_n;
        logic [RPM_W-1:0]         tach_rpm;
    } t_scan_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] stable_temperature;
        logic                     relay_on;
        logic                     duty_update;
        logic [DUTY_W-1:0]        duty_cycle;
        logic [SPEED_W-1:0]       speed_percent;
        logic [RPM_W-1:0]         display_value;
    } t_scan_result;

endpackage

// ===== hdl/fscd_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module fscd_div import fscd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_busy,
    output logic [DIV_Q_W-1:0] o_quotient
);

    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [DIV_D_W:0] shifted;
    logic [DIV_D_W:0] diff;
    logic             take;

    // The caller must keep the quotient within DIV_Q_W bits, which the block does not check;
    // the upper dividend bits start as the partial remainder and the low bits shift in one per step.
    always_comb begin
        shifted = {r_rem, r_quo[DIV_Q_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        take    = ~diff[DIV_D_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIV_N_W-1:DIV_Q_W];
            r_quo <= i_dividend[DIV_Q_W-1:0];
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= take ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_Q_W-2:0], take};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

// ===== hdl/fscd_filter.sv =====
// Stability filter: adopts a temperature after it repeats for enough scans.
module fscd_filter import fscd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_update,
    input  logic signed [TEMP_W-1:0] i_temp,
    output logic signed [TEMP_W-1:0] o_stable
);

    logic                     r_started;
    logic signed [TEMP_W-1:0] r_last;
    logic signed [TEMP_W-1:0] r_stable;
    logic [REPEAT_W-1:0]      r_count;

    logic signed [TEMP_W-1:0] last_eff;
    logic signed [TEMP_W-1:0] n_stable;
    logic [REPEAT_W-1:0]      cnt_eff;
    logic [REPEAT_W-1:0]      n_count;

    always_comb begin
        // first scan seeds the history with the reading itself
        last_eff = r_started ? r_last : i_temp;
        cnt_eff  = r_started ? r_count : '0;
        n_stable = r_started ? r_stable : i_temp;
        n_count  = (i_temp == last_eff) ? cnt_eff + 1'b1 : '0;
        if (n_count >= REPEAT_W'(STABLE_REPEATS)) begin
            n_stable = i_temp;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_last    <= '0;
            r_stable  <= '0;
            r_count   <= '0;
        end else if (i_update) begin
            r_started <= 1'b1;
            r_last    <= i_temp;
            r_stable  <= n_stable;
            r_count   <= n_count;
        end
    end

    assign o_stable = r_stable;

endmodule

// ===== hdl/fan_scan_duty_controller.sv =====
// Fan scan duty controller top level: sequencer, ratio setup and result register.
//
// One scan item is taken at a time; after acceptance it goes through a filter
// update, a 12-step bit-serial division that scales the pot, a setup step for
// the duty ratio, then a second 12-step division pass in which duty and speed
// are divided side by side on two divider units. The two divider passes set the
// item time, and no new item is accepted until the current result is loaded.
// The result sits in an output register, so the next item is accepted as soon
// as a result is loaded even if it has not been taken.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and should only change while no item is in flight.
module fan_scan_duty_controller import fscd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_scan_item            i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_scan_result          o_out
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILT  = 7'b0000010,
        S_POT   = 7'b0000100,
        S_SETUP = 7'b0001000,
        S_START = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [TEMP_W-1:0]   r_low_temp;
    logic signed [TEMP_W-1:0]   r_high_temp;
    logic signed [OFFSET_W-1:0] r_cal_offset;

    t_scan_item          r_item;
    t_scan_result        r_out;
    logic                r_out_valid;
    logic [POT_W-1:0]    r_pot_scaled;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_den;
    logic                r_on;
    logic                r_clamp;
    logic                r_full;

    logic [NUM_W-1:0]    n_num;
    logic [NUM_W-1:0]    n_den;
    logic                n_on;
    logic                n_clamp;

    logic signed [TEMP_W:0]   sum_temp;
    logic signed [TEMP_W-1:0] cal_temp;
    logic signed [TEMP_W-1:0] stable_temp;
    logic signed [TEMP_W:0]   ramp_range;
    logic signed [TEMP_W:0]   ramp_delta;
    logic signed [TEMP_W:0]   st_wide;
    logic [TEMP_W:0]          st_abs;

    logic                accept_in;
    logic                out_free;
    logic                filt_update;
    logic                div_a_start;
    logic                div_b_start;
    logic [DIV_N_W-1:0]  div_a_dividend;
    logic [DIV_D_W-1:0]  div_a_divisor;
    logic [DIV_N_W-1:0]  div_b_dividend;
    logic [DIV_D_W-1:0]  div_b_divisor;
    logic                div_a_busy;
    logic                div_b_busy;
    logic [DIV_Q_W-1:0]  div_a_quo;
    logic [DIV_Q_W-1:0]  div_b_quo;

    t_scan_result        n_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept_in  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_temp   <= TEMP_W'(CFG_LOW_TEMP_RST);
            r_high_temp  <= TEMP_W'(CFG_HIGH_TEMP_RST);
            r_cal_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LOW_TEMP:   r_low_temp   <= i_cfg_data[TEMP_W-1:0];
                CFG_HIGH_TEMP:  r_high_temp  <= i_cfg_data[TEMP_W-1:0];
                CFG_CAL_OFFSET: r_cal_offset <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Calibrated temperature, saturated to the signed field range
    always_comb begin
        sum_temp = {r_item.temperature_reading[TEMP_W-1], r_item.temperature_reading}
                 + {{(TEMP_W + 1 - OFFSET_W){r_cal_offset[OFFSET_W-1]}}, r_cal_offset};
        if (sum_temp > (TEMP_W + 1)'(2 ** (TEMP_W - 1) - 1)) begin
            cal_temp = {1'b0, {(TEMP_W - 1){1'b1}}};
        end else if (sum_temp < -(TEMP_W + 1)'(2 ** (TEMP_W - 1))) begin
            cal_temp = {1'b1, {(TEMP_W - 1){1'b0}}};
        end else begin
            cal_temp = sum_temp[TEMP_W-1:0];
        end
    end

    assign filt_update = (r_state == S_FILT);

    fscd_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (filt_update),
        .i_temp   (cal_temp),
        .o_stable (stable_temp)
    );

    // Divider A scales the pot first, then divides the duty; B divides speed.
    always_comb begin
        div_a_start = (r_state == S_FILT) || (r_state == S_START);
        div_b_start = (r_state == S_START);
        if (r_state == S_FILT) begin
            div_a_dividend = DIV_N_W'(r_item.pot_average & POT_STEP_MASK)
                           * DIV_N_W'(POT_SCALE_NUM);
            div_a_divisor  = DIV_D_W'(POT_SCALE_DEN);
        end else begin
            div_a_dividend = DIV_N_W'(r_num) * DIV_N_W'(PWM_PERIOD_COUNTS);
            div_a_divisor  = DIV_D_W'(r_den);
        end
        div_b_dividend = DIV_N_W'(r_num) * DIV_N_W'(SPEED_NUM_MUL) + DIV_N_W'(r_den);
        div_b_divisor  = {r_den, 1'b0};
    end

    fscd_div u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_a_start),
        .i_dividend (div_a_dividend),
        .i_divisor  (div_a_divisor),
        .o_busy     (div_a_busy),
        .o_quotient (div_a_quo)
    );

    fscd_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_b_start),
        .i_dividend (div_b_dividend),
        .i_divisor  (div_b_divisor),
        .o_busy     (div_b_busy),
        .o_quotient (div_b_quo)
    );

    // Ratio setup from the stable temperature or the scaled pot
    always_comb begin
        ramp_range = {r_high_temp[TEMP_W-1], r_high_temp}
                   - {r_low_temp[TEMP_W-1], r_low_temp};
        ramp_delta = {stable_temp[TEMP_W-1], stable_temp}
                   - {r_low_temp[TEMP_W-1], r_low_temp};
        n_num   = '0;
        n_den   = NUM_W'(1);
        n_on    = 1'b0;
        n_clamp = 1'b0;
        if (!r_item.temp_mode_switch_n) begin
            if (stable_temp >= r_low_temp) begin
                if (ramp_range == '0) begin
                    n_on    = 1'b1;
                    n_clamp = 1'b1;
                end else if (!ramp_range[TEMP_W]) begin
                    n_num = NUM_W'(ramp_range[TEMP_W-1:0])
                          + NUM_W'(ramp_delta[TEMP_W-1:0]) * NUM_W'(RAMP_SLOPE);
                    n_den = NUM_W'(ramp_range[TEMP_W-1:0]) * NUM_W'(RAMP_DEN_SCALE);
                    n_on  = 1'b1;
                end
            end
        end else if (!r_item.manual_mode_switch_n) begin
            n_num = NUM_W'(MANUAL_BASE) + NUM_W'(r_pot_scaled) * NUM_W'(RAMP_DEN_SCALE);
            n_den = NUM_W'(MANUAL_DEN);
            n_on  = 1'b1;
        end
    end

    // Result assembly
    always_comb begin
        st_wide = {stable_temp[TEMP_W-1], stable_temp};
        st_abs  = st_wide[TEMP_W] ? (TEMP_W + 1)'(-st_wide) : st_wide;
        n_out.stable_temperature = stable_temp;
        n_out.relay_on           = r_on;
        n_out.duty_update        = r_on;
        if (!r_on) begin
            n_out.duty_cycle    = '0;
            n_out.speed_percent = '0;
        end else if (r_full) begin
            n_out.duty_cycle    = DUTY_W'(DUTY_FULL);
            n_out.speed_percent = SPEED_W'(SPEED_FULL);
        end else begin
            n_out.duty_cycle    = div_a_quo[DUTY_W-1:0];
            n_out.speed_percent = div_b_quo[SPEED_W-1:0];
        end
        if (!r_item.temp_display_switch_n) begin
            n_out.display_value = RPM_W'(st_abs);
        end else if (!r_item.tach_display_switch_n) begin
            n_out.display_value = r_item.tach_rpm;
        end else begin
            n_out.display_value = RPM_W'(n_out.speed_percent);
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept_in) n_state = S_FILT;
            S_FILT:  n_state = S_POT;
            S_POT:   if (!div_a_busy) n_state = S_SETUP;
            S_SETUP: n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (!div_a_busy && !div_b_busy) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_item <= i_in;
        end
        if (r_state == S_POT && !div_a_busy) begin
            r_pot_scaled <= div_a_quo[POT_W-1:0];
        end
        if (r_state == S_SETUP) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_on    <= n_on;
            r_clamp <= n_clamp;
        end
        if (r_state == S_START) begin
            // saturate at the top of the scale when the ratio reaches one
            r_full <= r_clamp || (r_num >= r_den);
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/fscd_checker.sv =====
// Port-level checks for the fan scan duty controller, bound to the top level.
module fscd_checker import fscd_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         o_in_ready,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input t_scan_result o_out
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while busy");

    a_relay_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.relay_on == o_out.duty_update)
        else $error("relay and duty update disagree");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.relay_on |->
            o_out.duty_cycle == '0 && o_out.speed_percent == '0)
        else $error("fan off with nonzero duty or speed");

    a_on_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.relay_on |->
            o_out.speed_percent <= SPEED_W'(SPEED_FULL)
            && o_out.duty_cycle <= DUTY_W'(DUTY_FULL))
        else $error("duty or speed above full scale");

endmodule

bind fan_scan_duty_controller fscd_checker u_fscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== tb/tb_fan_scan_duty_controller.sv =====
// Testbench for the fan scan duty controller: directed and random scans checked against a predictor.
module tb_fan_scan_duty_controller;
    import fscd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Slowest run: ~1950 items, with sender gaps and receiver stalls; the limit
    // stays well above what that run needs.
    localparam int CYCLE_LIMIT      = 800_000;
    localparam int ITEMS_PER_PHASE  = 158;
    localparam int FIXED_PHASES     = 7;
    localparam int RANDOM_PHASES    = 4;
    localparam int IDLE_PERCENT     = 27;
    localparam int TAIL_CYCLES      = 40;

    // Duty math constants, kept apart from the design's own
    localparam int  POT_TRIM_MASK   = 'hFF0;
    localparam int  POT_GAIN_NUM    = 100368;
    localparam int  POT_GAIN_DEN    = 100000;
    localparam int  MANUAL_OFFSET   = 4096;
    localparam int  MANUAL_RANGE    = 409600;
    localparam int  TEMP_MAX        = 511;
    localparam int  TEMP_MIN        = -512;

    class duty_scoreboard;
        t_scan_result          pending_results[$];
        int                    errors;
        logic signed [9:0]     low_limit;
        logic signed [9:0]     high_limit;
        logic signed [7:0]     cal_offset;
        bit                    filter_running;
        int                    last_reading;
        int                    stable_reading;
        int                    repeat_run;

        function new();
            errors         = 0;
            low_limit      = 10'sd50;
            high_limit     = 10'sd100;
            cal_offset     = 8'sd0;
            filter_running = 1'b0;
            last_reading   = 0;
            stable_reading = 0;
            repeat_run     = 0;
        endfunction

        function void load_limits(logic [9:0] low, logic [9:0] high, logic [7:0] offset);
            low_limit  = low;
            high_limit = high;
            cal_offset = offset;
        endfunction

        // Work out the result of one accepted scan and queue it
        function void note_scan(t_scan_item s);
            int           t;
            int           low;
            int           high;
            int           span;
            int           st;
            int           pot;
            longint       num;
            longint       den;
            longint       duty;
            longint       speed;
            longint       disp;
            bit           fan_on;
            bit           full;
            t_scan_result res;

            t = int'($signed(s.temperature_reading)) + int'(cal_offset);
            if (t > TEMP_MAX) t = TEMP_MAX;
            if (t < TEMP_MIN) t = TEMP_MIN;

            if (!filter_running) begin
                last_reading   = t;
                stable_reading = t;
                repeat_run     = 0;
                filter_running = 1'b1;
            end
            if (t == last_reading)
                repeat_run = (repeat_run + 1) & 15;
            else
                repeat_run = 0;
            if (repeat_run >= STABLE_REPEATS) begin
                stable_reading = t;
                repeat_run     = 0;
            end
            last_reading = t;
            st = stable_reading;

            pot    = (int'(s.pot_average) & POT_TRIM_MASK) * POT_GAIN_NUM / POT_GAIN_DEN;
            low    = int'(low_limit);
            high   = int'(high_limit);
            num    = 0;
            den    = 1;
            fan_on = 1'b0;
            full   = 1'b0;

            // Temperature mode wins over manual mode
            if (!s.temp_mode_switch_n) begin
                if (st >= low) begin
                    span = high - low;
                    if (span == 0) begin
                        fan_on = 1'b1;
                        full   = 1'b1;
                    end else if (span > 0) begin
                        num    = span + 99 * (st - low);
                        den    = 100 * span;
                        fan_on = 1'b1;
                    end
                end
            end else if (!s.manual_mode_switch_n) begin
                num    = MANUAL_OFFSET + 100 * pot;
                den    = MANUAL_RANGE;
                fan_on = 1'b1;
            end

            duty  = 0;
            speed = 0;
            if (fan_on) begin
                if (full || num >= den) begin
                    duty  = (PWM_PERIOD_COUNTS * 999) / 1000;
                    speed = 100;
                end else begin
                    duty  = (num * PWM_PERIOD_COUNTS) / den;
                    speed = (200 * num + den) / (2 * den);
                end
            end

            if (!s.temp_display_switch_n)
                disp = (st < 0) ? -st : st;
            else if (!s.tach_display_switch_n)
                disp = s.tach_rpm;
            else
                disp = speed;

            res.stable_temperature = st[9:0];
            res.relay_on           = fan_on;
            res.duty_update        = fan_on;
            res.duty_cycle         = duty[11:0];
            res.speed_percent      = speed[6:0];
            res.display_value      = disp[16:0];
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_scan_result got);
            t_scan_result want;

            if (pending_results.size() == 0) begin
                $error("result with no scan outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("stable_temperature", int'($signed(want.stable_temperature)),
                          int'($signed(got.stable_temperature)));
            compare_field("relay_on", want.relay_on, got.relay_on);
            compare_field("duty_update", want.duty_update, got.duty_update);
            compare_field("duty_cycle", want.duty_cycle, got.duty_cycle);
            compare_field("speed_percent", want.speed_percent, got.speed_percent);
            compare_field("display_value", want.display_value, got.display_value);
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_LOW_TEMP;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_scan_item            i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_scan_result          o_out;

    duty_scoreboard sb = new();
    bit             steady = 1'b0;
    int             cycle_count = 0;

    fan_scan_duty_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL fan_scan_duty_controller");
            $finish;
        end
    end

    // Result side: check on each handshake, stall at random outside steady phases
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_result(o_out);
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic send_scan(t_scan_item s);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_scan(s);
    endtask

    // Hold the sender until every queued result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_fan_limits(int low, int high, int offset);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOW_TEMP;
        i_cfg_data  <= low[9:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_HIGH_TEMP;
        i_cfg_data  <= high[9:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_CAL_OFFSET;
        i_cfg_data  <= offset[9:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.load_limits(low[9:0], high[9:0], offset[7:0]);
    endtask

    function automatic t_scan_item random_scan(logic [9:0] reading);
        t_scan_item s;

        s.temperature_reading = reading;
        case ($urandom_range(9))
            0:       s.pot_average = '0;
            1:       s.pot_average = '1;
            2:       s.pot_average = POT_W'($urandom_range(15));
            default: s.pot_average = POT_W'($urandom_range(4095));
        endcase
        {s.temp_mode_switch_n, s.manual_mode_switch_n,
         s.temp_display_switch_n, s.tach_display_switch_n} = 4'($urandom_range(15));
        case ($urandom_range(9))
            0:       s.tach_rpm = '0;
            1:       s.tach_rpm = '1;
            default: s.tach_rpm = RPM_W'($urandom_range(131071));
        endcase
        return s;
    endfunction

    // Mostly runs of one temperature long enough to pass the filter, some noise
    task automatic run_phase(int items);
        int sent;
        int len;
        int target;
        int reading;
        int lo;
        int hi;
        int k;

        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 20) begin
                send_scan(random_scan(10'($urandom_range(1023))));
                sent++;
            end else begin
                lo = (sb.low_limit < sb.high_limit) ? int'(sb.low_limit) : int'(sb.high_limit);
                hi = (sb.low_limit < sb.high_limit) ? int'(sb.high_limit) : int'(sb.low_limit);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: target = int'($urandom_range(hi - lo)) + lo;
                    5, 6: begin
                        case ($urandom_range(7))
                            0:       target = int'(sb.low_limit) - 1;
                            1:       target = int'(sb.low_limit);
                            2:       target = int'(sb.low_limit) + 1;
                            3:       target = int'(sb.high_limit) - 1;
                            4:       target = int'(sb.high_limit);
                            5:       target = int'(sb.high_limit) + 1;
                            6:       target = TEMP_MIN;
                            default: target = TEMP_MAX;
                        endcase
                    end
                    default: target = int'($urandom_range(1023)) + TEMP_MIN;
                endcase
                reading = target - int'(sb.cal_offset);
                if (reading > TEMP_MAX) reading = TEMP_MAX;
                if (reading < TEMP_MIN) reading = TEMP_MIN;
                len = ($urandom_range(99) < 70) ? int'($urandom_range(22, 10))
                                                : int'($urandom_range(9, 1));
                for (k = 0; k < len; k++) begin
                    // break the run now and then
                    if ($urandom_range(99) < 4)
                        send_scan(random_scan(10'($urandom_range(1023))));
                    else
                        send_scan(random_scan(reading[9:0]));
                end
                sent += len;
            end
        end
    endtask

    initial begin
        int         fixed_low[FIXED_PHASES]    = '{-200, -512, 60, 100, 511, 0, -1};
        int         fixed_high[FIXED_PHASES]   = '{300, 511, 60, 20, -512, 1, 0};
        int         fixed_offset[FIXED_PHASES] = '{-128, 127, 5, 0, -1, 1, 127};
        int         pot_corners[6]             = '{0, 4095, 15, 16, 4080, 2048};
        t_scan_item s;
        int         i;
        int         p;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First scan, then runs at the coldest and hottest readings,
        // stepping through every switch setting
        for (i = 0; i < 23; i++) begin
            s = random_scan('0);
            if (i == 0)
                s.temperature_reading = 10'sd75;
            else if (i < 12)
                s.temperature_reading = 10'h200;
            else
                s.temperature_reading = 10'h1FF;
            s.pot_average = POT_W'(pot_corners[i % 6]);
            {s.temp_mode_switch_n, s.manual_mode_switch_n,
             s.temp_display_switch_n, s.tach_display_switch_n} = i[3:0];
            if (i % 3 == 0)
                s.tach_rpm = '0;
            else if (i % 3 == 1)
                s.tach_rpm = '1;
            send_scan(s);
        end
        run_phase(ITEMS_PER_PHASE);

        for (p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
            wait_drained();
            steady = (p == 1);
            if (p < FIXED_PHASES)
                load_fan_limits(fixed_low[p], fixed_high[p], fixed_offset[p]);
            else
                load_fan_limits(int'($urandom_range(1023)) + TEMP_MIN,
                                int'($urandom_range(1023)) + TEMP_MIN,
                                int'($urandom_range(255)) - 128);
            run_phase(ITEMS_PER_PHASE);
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS fan_scan_duty_controller");
        end else begin
            $display("FAIL fan_scan_duty_controller");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fscd_pkg.sv
hdl/fscd_div.sv
hdl/fscd_filter.sv
hdl/fan_scan_duty_controller.sv
hdl/fscd_checker.sv
tb/tb_fan_scan_duty_controller.sv
